// ===== rtl/core/binary_to_decimal_ascii_macros.svh =====
// Assertion macros shared by the converter modules.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define B2D_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in binary_to_decimal_ascii");

// The consequent holds in the cycle after the antecedent.
`define B2D_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in binary_to_decimal_ascii");

`endif

// ===== rtl/core/b2d_pkg.sv =====
`default_nettype none

package b2d_pkg;

  // Widths of the channel payloads.
  localparam int unsigned ValueW = 64;
  localparam int unsigned CharW  = 6;

  // ASCII code of the character '0'.
  localparam logic [CharW-1:0] ASCII_ZERO = 6'd48;

  // Status of the double dabble unit toward its neighbors.
  typedef struct packed {
    logic busy;
    logic done;
  } dd_stat_t;

  // Add-three correction of one BCD digit before it is doubled.
  function automatic logic [3:0] dd_adj(input logic [3:0] d);
    logic [3:0] r;
    r = (d >= 4'd5) ? 4'(d + 4'd3) : d;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/b2d_value_if.sv =====
`default_nettype none

// Request channel that carries one binary value.
interface b2d_value_if
  import b2d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b2d_digit_if.sv =====
`default_nettype none

// Request channel that carries one ASCII digit and its end marker.
interface b2d_digit_if
  import b2d_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] digit_char;
  logic             last_digit;

  modport source (output valid, output digit_char, output last_digit, input ready);
  modport sink (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/b2d_dabble.sv =====
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

// Bit-serial double dabble: one binary bit enters the BCD register per cycle.
module b2d_dabble
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned NumDigits  = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [ValueW-1:0]      value_i,
  output      dd_stat_t               stat_o,
  output      logic [NumDigits*4-1:0] bcd_o
);

  localparam int unsigned BcdW = NumDigits * 4;
  localparam int unsigned CntW = $clog2(VALUE_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic [BcdW-1:0]       bcd_adj;

  // Correct every digit that would overflow once it is doubled.
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[4*i +: 4] = dd_adj(bcd_q[4*i +: 4]);
    end
  end

  // Load a new value, or shift one bit per cycle until all bits are in.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(VALUE_BITS);
      bin_d  = value_i[VALUE_BITS-1:0];
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Data shift registers.
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign bcd_o       = bcd_q;

  // The bit counter is never empty while the unit shifts.
  `B2D_ASSERT_SAME(a_busy_cnt, busy_q, cnt_q != '0)
  // The final shift raises done in the next cycle.
  `B2D_ASSERT_NEXT(a_last_done, busy_q && !start_i && cnt_q == CntW'(1), done_q)
  // Done and busy are never high together.
  `B2D_ASSERT_SAME(a_done_idle, done_q, !busy_q)

endmodule

`default_nettype wire

// ===== rtl/core/b2d_emit.sv =====
`default_nettype none

`include "binary_to_decimal_ascii_macros.svh"

// Digit emitter: skips leading zeros, then sends one digit per cycle while the sink is ready.
module b2d_emit
  import b2d_pkg::*;
#(
  parameter int unsigned NumDigits = 20
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire logic [NumDigits*4-1:0] bcd_i,
  output      logic                   idle_o,
  b2d_digit_if.source                 out_o
);

  localparam int unsigned BcdW  = NumDigits * 4;
  localparam int unsigned LeftW = $clog2(NumDigits + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSkip = 2'd1;
  localparam logic [1:0] StSend = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [LeftW-1:0] left_q, left_d;
  logic [BcdW-1:0]  bcd_q, bcd_d;
  logic [3:0]       top_digit;
  logic             one_left;

  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign one_left  = (left_q == LeftW'(1));

  // Sequencer over the digit register, most significant digit first.
  always_comb begin
    state_d = state_q;
    left_d  = left_q;
    bcd_d   = bcd_q;
    unique case (state_q)
      StIdle: begin
        if (load_i) begin
          state_d = StSkip;
          left_d  = LeftW'(NumDigits);
          bcd_d   = bcd_i;
        end
      end
      StSkip: begin
        if (top_digit == 4'd0 && !one_left) begin
          left_d = left_q - LeftW'(1);
          bcd_d  = {bcd_q[BcdW-5:0], 4'b0000};
        end else begin
          state_d = StSend;
        end
      end
      StSend: begin
        if (out_o.ready) begin
          if (one_left) begin
            state_d = StIdle;
          end else begin
            left_d = left_q - LeftW'(1);
            bcd_d  = {bcd_q[BcdW-5:0], 4'b0000};
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      left_q  <= left_d;
    end
  end

  // Digit shift register.
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
  end

  assign idle_o           = (state_q == StIdle);
  assign out_o.valid      = (state_q == StSend);
  assign out_o.digit_char = ASCII_ZERO + {2'b00, top_digit};
  assign out_o.last_digit = one_left;

  // A digit is only offered while digits remain.
  `B2D_ASSERT_SAME(a_send_left, state_q == StSend, left_q != '0)
  // Taking the final digit returns the emitter to idle.
  `B2D_ASSERT_NEXT(a_last_idle, state_q == StSend && out_o.ready && one_left,
                   state_q == StIdle)
  // A skipped leading zero uses up one digit position.
  `B2D_ASSERT_NEXT(a_skip_count, state_q == StSkip && top_digit == 4'd0 && !one_left,
                   left_q == $past(left_q) - LeftW'(1))

endmodule

`default_nettype wire

// ===== rtl/core/binary_to_decimal_ascii.sv =====
// Flow: a value is accepted only while the double dabble unit and the emitter are idle;
// the unit shifts its bits into the BCD register one bit per cycle, and the emitter then
// loads the digits, skips the leading zero digits and offers the first digit. A new
// value is not taken until the last digit of the previous one has been taken.
// Reset: rst_ni clears the control state asynchronously; the block is then idle.
`default_nettype none

module binary_to_decimal_ascii
  import b2d_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b2d_value_if.sink   in_i,
  b2d_digit_if.source out_o
);

  // Decimal digits needed for the largest VALUE_BITS-bit value.
  localparam int unsigned NumDigits = (VALUE_BITS * 30103) / 100000 + 1;

  dd_stat_t                 dd_stat;
  logic [NumDigits*4-1:0]   dd_bcd;
  logic                     emit_idle;
  logic                     start;

  // One value is in flight at a time.
  assign in_i.ready = !dd_stat.busy && !dd_stat.done && emit_idle;
  assign start      = in_i.valid && in_i.ready;

  b2d_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NumDigits  (NumDigits)
  ) u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (in_i.value),
    .stat_o  (dd_stat),
    .bcd_o   (dd_bcd)
  );

  b2d_emit #(
    .NumDigits (NumDigits)
  ) u_emit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (dd_stat.done),
    .bcd_i  (dd_bcd),
    .idle_o (emit_idle),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire
